/* design/pslf_pkg.sv */
// Shared types, widths and fixed-point helpers for the paired statistics block.
// Depends on nothing; the top level takes everything here by scoped names.
`default_nettype none

package pslf_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned MAX_POINTS    = 1024;
  localparam int unsigned ONE           = 1 << FRACTION_BITS;

  localparam int unsigned CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int unsigned PROD_W  = 2 * DATA_W;
  localparam int unsigned RS_W    = PROD_W - FRACTION_BITS + 1;
  localparam int unsigned SX_W    = DATA_W + CNT_W - 1;
  localparam int unsigned SXX_W   = PROD_W - FRACTION_BITS + CNT_W - 1;
  localparam int unsigned MAG_W   = SXX_W;
  localparam int unsigned NUM_W   = MAG_W + 1;
  localparam int unsigned QS_W    = NUM_W + 1;
  localparam int unsigned WIDE_W  = QS_W + 1;
  localparam int unsigned DEN_W   = DATA_W;
  localparam int unsigned VAR_W   = DATA_W - 1;
  localparam int unsigned CORR_W  = FRACTION_BITS + 2;
  localparam int unsigned SQ_W    = 2 * (DATA_W - 1);
  localparam int unsigned SQ_ITER = SQ_W / 2;

  localparam int unsigned DIV_CNT_W = $clog2(NUM_W);
  localparam int unsigned SQ_CNT_W  = $clog2(SQ_ITER);

  localparam logic signed [WIDE_W-1:0] S32_MAX = {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] S32_MIN = {{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
  localparam logic signed [CORR_W-1:0] CORR_MAX = CORR_W'(ONE);
  localparam logic signed [CORR_W-1:0] CORR_MIN = -CORR_MAX;

  typedef enum logic [22:0] {
    ST_IDLE  = 23'd1,
    ST_ACC0  = 23'd2,
    ST_ACC1  = 23'd4,
    ST_ACC2  = 23'd8,
    ST_ACC3  = 23'd16,
    ST_QRY0  = 23'd32,
    ST_QRY1  = 23'd64,
    ST_FMX   = 23'd128,
    ST_FMY   = 23'd256,
    ST_FEXX  = 23'd512,
    ST_FEYY  = 23'd1024,
    ST_FEXY  = 23'd2048,
    ST_FCOV  = 23'd4096,
    ST_FDIVS = 23'd8192,
    ST_FSLP  = 23'd16384,
    ST_FMUL  = 23'd32768,
    ST_FICP  = 23'd65536,
    ST_FSQ   = 23'd131072,
    ST_SQRT  = 23'd262144,
    ST_FCOR  = 23'd524288,
    ST_FCORE = 23'd1048576,
    ST_DIV   = 23'd2097152,
    ST_EMIT  = 23'd4194304
  } state_e;

  // Rescale a full product to the fraction format, rounding half away from zero.
  function automatic logic signed [RS_W-1:0] rnd_shift(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] r;
    logic signed [RS_W-1:0] res;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    r   = (mag + (PROD_W'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    res = RS_W'(r);
    return p[PROD_W-1] ? -res : res;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [WIDE_W-1:0] v);
    logic signed [DATA_W-1:0] res;
    if (v > S32_MAX) begin
      res = S32_MAX[DATA_W-1:0];
    end else if (v < S32_MIN) begin
      res = S32_MIN[DATA_W-1:0];
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [VAR_W-1:0] sat_u31(input logic signed [WIDE_W-1:0] v);
    logic [VAR_W-1:0] res;
    if (v[WIDE_W-1]) begin
      res = '0;
    end else if (v > S32_MAX) begin
      res = '1;
    end else begin
      res = v[VAR_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* design/paired_statistics_linear_fit.sv */
// Paired statistics and least-squares line over signed Q16.16 samples.
// Uses pslf_pkg for widths, the sequencer states and the rounding helpers.
`default_nettype none

// One item is worked on at a time, and in_stall_o is high until the block is back
// in its idle state. All products go through one shared 32x32 multiplier; an added
// sample runs the states ACC0 to ACC3 and a query QRY0 and QRY1, and then ST_EMIT
// hands the item to the output register. A sample marked last also runs the set
// statistics: up to seven passes through a shared restoring divider of 59 one-bit
// steps each and 31 square-root steps. The output register holds a result until
// it is taken, and a new input item is accepted while it waits.
module paired_statistics_linear_fit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    operation_i,
  input  logic signed [pslf_pkg::DATA_W-1:0]      sample_x_i,
  input  logic signed [pslf_pkg::DATA_W-1:0]      sample_y_i,
  input  logic                                    is_last_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic                                    result_kind_o,
  output logic        [pslf_pkg::CNT_W-1:0]       sample_count_o,
  output logic signed [pslf_pkg::DATA_W-1:0]      mean_x_o,
  output logic signed [pslf_pkg::DATA_W-1:0]      mean_y_o,
  output logic        [pslf_pkg::VAR_W-1:0]       variance_x_o,
  output logic        [pslf_pkg::VAR_W-1:0]       variance_y_o,
  output logic signed [pslf_pkg::DATA_W-1:0]      covariance_o,
  output logic signed [pslf_pkg::CORR_W-1:0]      correlation_o,
  output logic signed [pslf_pkg::DATA_W-1:0]      slope_o,
  output logic signed [pslf_pkg::DATA_W-1:0]      intercept_o,
  output logic        [pslf_pkg::VAR_W-1:0]       deviation_o,
  output logic                                    degenerate_o
);

  localparam int unsigned DATA_W = pslf_pkg::DATA_W;
  localparam int unsigned WIDE_W = pslf_pkg::WIDE_W;

  pslf_pkg::state_e state_q, state_d, ret_q, ret_d;

  // Captured item
  logic signed [DATA_W-1:0] x_q, y_q;
  logic kind_q, last_q, take_q;

  // Running sums
  logic [pslf_pkg::CNT_W-1:0] count_q;
  logic signed [pslf_pkg::SX_W-1:0] sum_x_q, sum_y_q;
  logic signed [pslf_pkg::SXX_W-1:0] sum_xx_q, sum_yy_q, sum_xy_q;

  // Stored line and working results
  logic signed [DATA_W-1:0] line_slope_q, line_icpt_q;
  logic signed [DATA_W-1:0] mx_q, my_q, cv_q;
  logic [pslf_pkg::VAR_W-1:0] vx_q, vy_q, dev_q;
  logic signed [pslf_pkg::CORR_W-1:0] corr_q;
  logic degen_q;

  // Shared multiplier
  logic mul_en;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [pslf_pkg::PROD_W-1:0] prod_q;
  logic signed [pslf_pkg::RS_W-1:0] rs_prod;

  // Shared divider
  logic div_start;
  logic signed [pslf_pkg::SXX_W-1:0] div_a;
  logic [pslf_pkg::DEN_W-1:0] div_b;
  logic [pslf_pkg::MAG_W-1:0] div_mag;
  logic [pslf_pkg::NUM_W-1:0] div_num_q;
  logic [pslf_pkg::DEN_W-1:0] div_den_q, div_rem_q;
  logic [pslf_pkg::DEN_W:0] div_rem_sh;
  logic div_ge, div_neg_q;
  logic [pslf_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic signed [pslf_pkg::QS_W-1:0] div_quo;

  // Square root
  logic [pslf_pkg::SQ_W-1:0] sq_v_q, sq_r_q, sq_bit_q, sq_sum;
  logic sq_ge;
  logic [pslf_pkg::SQ_CNT_W-1:0] sq_cnt_q;

  logic signed [WIDE_W-1:0] quo_w, rs_w, diff_w, dev_w, dev_abs;
  logic signed [pslf_pkg::SXX_W-1:0] cv_scaled;
  logic out_valid_q, out_load;

  assign in_stall_o  = (state_q != pslf_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_load    = (state_q == pslf_pkg::ST_EMIT) && (!out_valid_q || !out_stall_i);

  assign rs_prod   = pslf_pkg::rnd_shift(prod_q);
  assign quo_w     = WIDE_W'(div_quo);
  assign rs_w      = WIDE_W'(rs_prod);
  assign diff_w    = quo_w - rs_w;
  assign dev_w     = rs_w + WIDE_W'(line_icpt_q) - WIDE_W'(y_q);
  assign dev_abs   = dev_w[WIDE_W-1] ? -dev_w : dev_w;
  assign cv_scaled = pslf_pkg::SXX_W'(cv_q) <<< pslf_pkg::FRACTION_BITS;

  assign div_mag    = div_a[pslf_pkg::SXX_W-1] ? pslf_pkg::MAG_W'(-div_a)
                                               : pslf_pkg::MAG_W'(div_a);
  assign div_rem_sh = {div_rem_q, div_num_q[pslf_pkg::NUM_W-1]};
  assign div_ge     = (div_rem_sh >= {1'b0, div_den_q});
  assign div_quo    = div_neg_q ? -$signed({1'b0, div_num_q}) : $signed({1'b0, div_num_q});

  assign sq_sum = sq_r_q + sq_bit_q;
  assign sq_ge  = (sq_v_q >= sq_sum);

  // Sequencer and operand selection for the shared units.
  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      pslf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = operation_i ? pslf_pkg::ST_QRY0 : pslf_pkg::ST_ACC0;
        end
      end
      pslf_pkg::ST_ACC0: begin
        mul_en = 1'b1; mul_a = x_q; mul_b = x_q;
        state_d = pslf_pkg::ST_ACC1;
      end
      pslf_pkg::ST_ACC1: begin
        mul_en = 1'b1; mul_a = y_q; mul_b = y_q;
        state_d = pslf_pkg::ST_ACC2;
      end
      pslf_pkg::ST_ACC2: begin
        mul_en = 1'b1; mul_a = x_q; mul_b = y_q;
        state_d = pslf_pkg::ST_ACC3;
      end
      pslf_pkg::ST_ACC3: begin
        state_d = last_q ? pslf_pkg::ST_FMX : pslf_pkg::ST_IDLE;
      end
      pslf_pkg::ST_QRY0: begin
        mul_en = 1'b1; mul_a = line_slope_q; mul_b = x_q;
        state_d = pslf_pkg::ST_QRY1;
      end
      pslf_pkg::ST_QRY1: begin
        state_d = pslf_pkg::ST_EMIT;
      end
      pslf_pkg::ST_FMX: begin
        if (count_q == '0) begin
          state_d = pslf_pkg::ST_EMIT;
        end else begin
          div_start = 1'b1; div_a = pslf_pkg::SXX_W'(sum_x_q);
          div_b = pslf_pkg::DEN_W'(count_q);
          ret_d = pslf_pkg::ST_FMY; state_d = pslf_pkg::ST_DIV;
        end
      end
      pslf_pkg::ST_FMY: begin
        div_start = 1'b1; div_a = pslf_pkg::SXX_W'(sum_y_q);
        div_b = pslf_pkg::DEN_W'(count_q);
        ret_d = pslf_pkg::ST_FEXX; state_d = pslf_pkg::ST_DIV;
      end
      pslf_pkg::ST_FEXX: begin
        mul_en = 1'b1; mul_a = mx_q; mul_b = mx_q;
        div_start = 1'b1; div_a = sum_xx_q; div_b = pslf_pkg::DEN_W'(count_q);
        ret_d = pslf_pkg::ST_FEYY; state_d = pslf_pkg::ST_DIV;
      end
      pslf_pkg::ST_FEYY: begin
        mul_en = 1'b1; mul_a = my_q; mul_b = my_q;
        div_start = 1'b1; div_a = sum_yy_q; div_b = pslf_pkg::DEN_W'(count_q);
        ret_d = pslf_pkg::ST_FEXY; state_d = pslf_pkg::ST_DIV;
      end
      pslf_pkg::ST_FEXY: begin
        mul_en = 1'b1; mul_a = mx_q; mul_b = my_q;
        div_start = 1'b1; div_a = sum_xy_q; div_b = pslf_pkg::DEN_W'(count_q);
        ret_d = pslf_pkg::ST_FCOV; state_d = pslf_pkg::ST_DIV;
      end
      pslf_pkg::ST_FCOV: begin
        state_d = pslf_pkg::ST_FDIVS;
      end
      pslf_pkg::ST_FDIVS: begin
        // With no spread in x there is no line; slope and intercept stay zero.
        if (vx_q == '0) begin
          state_d = pslf_pkg::ST_EMIT;
        end else begin
          div_start = 1'b1; div_a = cv_scaled; div_b = pslf_pkg::DEN_W'(vx_q);
          ret_d = pslf_pkg::ST_FSLP; state_d = pslf_pkg::ST_DIV;
        end
      end
      pslf_pkg::ST_FSLP: begin
        state_d = pslf_pkg::ST_FMUL;
      end
      pslf_pkg::ST_FMUL: begin
        mul_en = 1'b1; mul_a = line_slope_q; mul_b = mx_q;
        state_d = pslf_pkg::ST_FICP;
      end
      pslf_pkg::ST_FICP: begin
        mul_en = 1'b1; mul_a = DATA_W'(vx_q); mul_b = DATA_W'(vy_q);
        state_d = degen_q ? pslf_pkg::ST_EMIT : pslf_pkg::ST_FSQ;
      end
      pslf_pkg::ST_FSQ: begin
        state_d = pslf_pkg::ST_SQRT;
      end
      pslf_pkg::ST_SQRT: begin
        if (sq_cnt_q == pslf_pkg::SQ_CNT_W'(pslf_pkg::SQ_ITER - 1)) begin
          state_d = pslf_pkg::ST_FCOR;
        end
      end
      pslf_pkg::ST_FCOR: begin
        div_start = 1'b1; div_a = cv_scaled; div_b = pslf_pkg::DEN_W'(sq_r_q);
        ret_d = pslf_pkg::ST_FCORE; state_d = pslf_pkg::ST_DIV;
      end
      pslf_pkg::ST_FCORE: begin
        state_d = pslf_pkg::ST_EMIT;
      end
      pslf_pkg::ST_DIV: begin
        if (div_cnt_q == pslf_pkg::DIV_CNT_W'(pslf_pkg::NUM_W - 1)) begin
          state_d = ret_q;
        end
      end
      pslf_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = pslf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pslf_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state, running sums and the stored line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pslf_pkg::ST_IDLE;
      ret_q        <= pslf_pkg::ST_IDLE;
      out_valid_q  <= 1'b0;
      count_q      <= '0;
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      sum_xx_q     <= '0;
      sum_yy_q     <= '0;
      sum_xy_q     <= '0;
      line_slope_q <= '0;
      line_icpt_q  <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        pslf_pkg::ST_ACC0: begin
          if (take_q) begin
            count_q <= count_q + 1'b1;
            sum_x_q <= sum_x_q + pslf_pkg::SX_W'(x_q);
            sum_y_q <= sum_y_q + pslf_pkg::SX_W'(y_q);
          end
        end
        pslf_pkg::ST_ACC1: begin
          if (take_q) sum_xx_q <= sum_xx_q + pslf_pkg::SXX_W'(rs_prod);
        end
        pslf_pkg::ST_ACC2: begin
          if (take_q) sum_yy_q <= sum_yy_q + pslf_pkg::SXX_W'(rs_prod);
        end
        pslf_pkg::ST_ACC3: begin
          if (take_q) sum_xy_q <= sum_xy_q + pslf_pkg::SXX_W'(rs_prod);
        end
        pslf_pkg::ST_FMX: begin
          line_slope_q <= '0;
          line_icpt_q  <= '0;
        end
        pslf_pkg::ST_FSLP: begin
          line_slope_q <= pslf_pkg::sat_s32(quo_w);
        end
        pslf_pkg::ST_FICP: begin
          line_icpt_q <= pslf_pkg::sat_s32(WIDE_W'(my_q) - rs_w);
        end
        pslf_pkg::ST_EMIT: begin
          // The set is finished once its statistics leave; start a fresh one.
          if (out_load && !kind_q) begin
            count_q  <= '0;
            sum_x_q  <= '0;
            sum_y_q  <= '0;
            sum_xx_q <= '0;
            sum_yy_q <= '0;
            sum_xy_q <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == pslf_pkg::ST_IDLE && in_valid_i) begin
      x_q    <= sample_x_i;
      y_q    <= sample_y_i;
      kind_q <= operation_i;
      last_q <= is_last_i;
      take_q <= (count_q < pslf_pkg::CNT_W'(pslf_pkg::MAX_POINTS));
    end

    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end

    if (div_start) begin
      div_neg_q <= div_a[pslf_pkg::SXX_W-1];
      div_num_q <= pslf_pkg::NUM_W'(div_mag) + pslf_pkg::NUM_W'(div_b >> 1);
      div_den_q <= div_b;
      div_rem_q <= '0;
      div_cnt_q <= '0;
    end else if (state_q == pslf_pkg::ST_DIV) begin
      div_rem_q <= div_ge ? div_rem_sh[pslf_pkg::DEN_W-1:0] - div_den_q
                          : div_rem_sh[pslf_pkg::DEN_W-1:0];
      div_num_q <= {div_num_q[pslf_pkg::NUM_W-2:0], div_ge};
      div_cnt_q <= div_cnt_q + 1'b1;
    end

    case (state_q)
      pslf_pkg::ST_QRY1: begin
        dev_q <= pslf_pkg::sat_u31(dev_abs);
      end
      pslf_pkg::ST_FMX: begin
        mx_q    <= '0;
        my_q    <= '0;
        vx_q    <= '0;
        vy_q    <= '0;
        cv_q    <= '0;
        corr_q  <= '0;
        degen_q <= 1'b1;
      end
      pslf_pkg::ST_FMY: begin
        mx_q <= div_quo[DATA_W-1:0];
      end
      pslf_pkg::ST_FEXX: begin
        my_q <= div_quo[DATA_W-1:0];
      end
      pslf_pkg::ST_FEYY: begin
        vx_q <= pslf_pkg::sat_u31(diff_w);
      end
      pslf_pkg::ST_FEXY: begin
        vy_q <= pslf_pkg::sat_u31(diff_w);
      end
      pslf_pkg::ST_FCOV: begin
        cv_q    <= pslf_pkg::sat_s32(diff_w);
        degen_q <= (vx_q == '0) || (vy_q == '0);
      end
      pslf_pkg::ST_FSQ: begin
        sq_v_q   <= prod_q[pslf_pkg::SQ_W-1:0];
        sq_r_q   <= '0;
        sq_bit_q <= pslf_pkg::SQ_W'(1) << (pslf_pkg::SQ_W - 2);
        sq_cnt_q <= '0;
      end
      pslf_pkg::ST_SQRT: begin
        if (sq_ge) begin
          sq_v_q <= sq_v_q - sq_sum;
          sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
        end else begin
          sq_r_q <= sq_r_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
        sq_cnt_q <= sq_cnt_q + 1'b1;
      end
      pslf_pkg::ST_FCORE: begin
        if (div_quo > pslf_pkg::QS_W'(pslf_pkg::CORR_MAX)) begin
          corr_q <= pslf_pkg::CORR_MAX;
        end else if (div_quo < pslf_pkg::QS_W'(pslf_pkg::CORR_MIN)) begin
          corr_q <= pslf_pkg::CORR_MIN;
        end else begin
          corr_q <= div_quo[pslf_pkg::CORR_W-1:0];
        end
      end
      default: begin
      end
    endcase

    if (out_load) begin
      result_kind_o <= kind_q;
      if (kind_q) begin
        sample_count_o <= '0;
        mean_x_o       <= '0;
        mean_y_o       <= '0;
        variance_x_o   <= '0;
        variance_y_o   <= '0;
        covariance_o   <= '0;
        correlation_o  <= '0;
        slope_o        <= '0;
        intercept_o    <= '0;
        deviation_o    <= dev_q;
        degenerate_o   <= 1'b0;
      end else begin
        sample_count_o <= count_q;
        mean_x_o       <= mx_q;
        mean_y_o       <= my_q;
        variance_x_o   <= vx_q;
        variance_y_o   <= vy_q;
        covariance_o   <= cv_q;
        correlation_o  <= corr_q;
        slope_o        <= line_slope_q;
        intercept_o    <= line_icpt_q;
        deviation_o    <= '0;
        degenerate_o   <= degen_q;
      end
    end
  end

`ifndef SYNTH
  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == pslf_pkg::ST_EMIT))
    else $error("result appeared outside the emit state");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=>
      (state_q == pslf_pkg::ST_ACC0 || state_q == pslf_pkg::ST_QRY0))
    else $error("accepted item did not start work");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pslf_pkg::CNT_W'(pslf_pkg::MAX_POINTS))
    else $error("sample count beyond set capacity");

  a_corr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !result_kind_o) |->
      (correlation_o <= pslf_pkg::CORR_MAX && correlation_o >= pslf_pkg::CORR_MIN))
    else $error("correlation outside unit range");
`endif

endmodule

`default_nettype wire

/* sim/paired_statistics_linear_fit_tb.sv */
// Self-checking testbench for paired_statistics_linear_fit: directed table, then random sets.
// Depends on pslf_pkg and the block itself; results are predicted in place and checked in order.
`timescale 1ns / 100ps

module paired_statistics_linear_fit_tb;

  localparam int unsigned DATA_W        = pslf_pkg::DATA_W;
  localparam int unsigned CNT_W         = pslf_pkg::CNT_W;
  localparam int unsigned VAR_W         = pslf_pkg::VAR_W;
  localparam int unsigned CORR_W        = pslf_pkg::CORR_W;
  localparam int unsigned FRACTION_BITS = pslf_pkg::FRACTION_BITS;
  localparam int unsigned MAX_POINTS    = pslf_pkg::MAX_POINTS;

  localparam longint FX_ONE    = longint'(1) << FRACTION_BITS;
  localparam longint POS_MAX   = 64'sd2147483647;
  localparam longint NEG_MIN   = -64'sd2147483648;
  localparam int     WATCH_LIM = 20000;
  localparam bit     OP_ADD    = 1'b0;
  localparam bit     OP_QUERY  = 1'b1;

  typedef struct {
    bit                   kind;
    logic [CNT_W-1:0]     count;
    logic [DATA_W-1:0]    mean_x;
    logic [DATA_W-1:0]    mean_y;
    logic [VAR_W-1:0]     var_x;
    logic [VAR_W-1:0]     var_y;
    logic [DATA_W-1:0]    cov;
    logic [CORR_W-1:0]    corr;
    logic [DATA_W-1:0]    slope;
    logic [DATA_W-1:0]    icpt;
    logic [VAR_W-1:0]     dev;
    bit                   degen;
  } fit_result_t;

  typedef struct {
    bit          op;
    longint      x;
    longint      y;
    bit          last;
    bit          typed;
    fit_result_t res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic operation_i = 1'b0;
  logic signed [DATA_W-1:0] sample_x_i = '0;
  logic signed [DATA_W-1:0] sample_y_i = '0;
  logic is_last_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic result_kind_o;
  logic [CNT_W-1:0] sample_count_o;
  logic signed [DATA_W-1:0] mean_x_o, mean_y_o, covariance_o, slope_o, intercept_o;
  logic [VAR_W-1:0] variance_x_o, variance_y_o, deviation_o;
  logic signed [CORR_W-1:0] correlation_o;
  logic degenerate_o;

  paired_statistics_linear_fit u_top (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Predictor state.
  longint pts, acc_x, acc_y, acc_xx, acc_yy, acc_xy, fit_slope, fit_icpt;

  fit_result_t pending_fits[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_cnt = 0;
  int items_sent = 0;
  int results_seen = 0;
  int sets_done = 0;
  int quiet_cycles = 0;
  bit sending = 1'b0;

  function automatic void fit_pts_reset();
    pts = 0;
    acc_x = 0;
    acc_y = 0;
    acc_xx = 0;
    acc_yy = 0;
    acc_xy = 0;
    fit_slope = 0;
    fit_icpt = 0;
  endfunction

  function automatic longint round_div(longint a, longint d);
    longint unsigned mag;
    longint unsigned q;
    mag = a < 0 ? -a : a;
    q = (mag + longint'(d) / 2) / d;
    return a < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // Applies one accepted item to the predictor; returns 1 when it yields a result.
  function automatic bit predict_fit(bit op, longint x, longint y, bit last,
                                     output fit_result_t r);
    longint d, mx, my, vx, vy, cv, slp, icp, corr, den;
    bit degen;
    r = '{default: 0};
    if (op == OP_QUERY) begin
      d = round_div(fit_slope * x, FX_ONE) + fit_icpt - y;
      if (d < 0) d = -d;
      r.kind = 1'b1;
      r.dev = VAR_W'(clamp(d, 0, POS_MAX));
      return 1'b1;
    end
    if (pts < MAX_POINTS) begin
      pts++;
      acc_x += x;
      acc_y += y;
      acc_xx += round_div(x * x, FX_ONE);
      acc_yy += round_div(y * y, FX_ONE);
      acc_xy += round_div(x * y, FX_ONE);
    end
    if (!last) return 1'b0;
    mx = round_div(acc_x, pts);
    my = round_div(acc_y, pts);
    vx = clamp(round_div(acc_xx, pts) - round_div(mx * mx, FX_ONE), 0, POS_MAX);
    vy = clamp(round_div(acc_yy, pts) - round_div(my * my, FX_ONE), 0, POS_MAX);
    cv = clamp(round_div(acc_xy, pts) - round_div(mx * my, FX_ONE), NEG_MIN, POS_MAX);
    mx = clamp(mx, NEG_MIN, POS_MAX);
    my = clamp(my, NEG_MIN, POS_MAX);
    degen = (vx == 0) || (vy == 0);
    slp = 0;
    icp = 0;
    corr = 0;
    if (vx != 0) begin
      slp = clamp(round_div(cv * FX_ONE, vx), NEG_MIN, POS_MAX);
      icp = clamp(my - round_div(slp * mx, FX_ONE), NEG_MIN, POS_MAX);
    end
    if (!degen) begin
      den = floor_sqrt(longint'(vx) * longint'(vy));
      if (den > 0) corr = clamp(round_div(cv * FX_ONE, den), -FX_ONE, FX_ONE);
    end
    r.count = CNT_W'(pts);
    r.mean_x = DATA_W'(mx);
    r.mean_y = DATA_W'(my);
    r.var_x = VAR_W'(vx);
    r.var_y = VAR_W'(vy);
    r.cov = DATA_W'(cv);
    r.corr = CORR_W'(corr);
    r.slope = DATA_W'(slp);
    r.icpt = DATA_W'(icp);
    r.degen = degen;
    fit_slope = slp;
    fit_icpt = icp;
    pts = 0;
    acc_x = 0;
    acc_y = 0;
    acc_xx = 0;
    acc_yy = 0;
    acc_xy = 0;
    return 1'b1;
  endfunction

  // Offers one item and returns at the edge where it is taken.
  task automatic send_item(bit op, longint x, longint y, bit last,
                           bit typed = 1'b0, fit_result_t typed_res = '{default: 0});
    fit_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    sample_x_i  <= x[DATA_W-1:0];
    sample_y_i  <= y[DATA_W-1:0];
    is_last_i   <= last;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (predict_fit(op, x, y, last, r)) begin
      pending_fits.push_back(typed ? typed_res : r);
      if (op == OP_ADD) sets_done++;
    end
  endtask

  function automatic longint pick_value(int mode);
    case (mode)
      0: return longint'($signed($urandom()));
      1: return $urandom_range(1) ? POS_MAX : NEG_MIN;
      2: return longint'($urandom_range(0, 2 ** 22)) - 2 ** 21;
      default: return longint'($urandom_range(0, 2 ** 26)) - 2 ** 25;
    endcase
  endfunction

  task automatic send_set(int len, int shape);
    longint cx, cy;
    int mode;
    mode = $urandom_range(3);
    cx = pick_value(mode);
    cy = pick_value(mode);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(15) == 0) send_item(OP_QUERY, pick_value(mode), pick_value(mode), 1'b0);
      send_item(OP_ADD, shape == 1 ? cx : pick_value(mode), shape == 2 ? cy : pick_value(mode),
                i == len - 1);
    end
  endtask

  task automatic run_random(int n_items);
    int stop_at;
    int pick;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(9);
      case (pick)
        6:       send_item(OP_QUERY, pick_value($urandom_range(3)), pick_value($urandom_range(3)),
                           $urandom_range(1));
        7:       send_set(1, 0);
        8:       send_set($urandom_range(2, 6), 1);
        9:       send_set($urandom_range(2, 6), 2);
        default: send_set($urandom_range(2, 12), 0);
      endcase
    end
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    fit_result_t w;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_fits.size() == 0) begin
          $error("result item arrived with nothing expected");
          fail_cnt++;
        end else begin
          w = pending_fits.pop_front();
          check_field("result_kind", w.kind, result_kind_o);
          check_field("sample_count", w.count, sample_count_o);
          check_field("mean_x", w.mean_x, $unsigned(mean_x_o));
          check_field("mean_y", w.mean_y, $unsigned(mean_y_o));
          check_field("variance_x", w.var_x, variance_x_o);
          check_field("variance_y", w.var_y, variance_y_o);
          check_field("covariance", w.cov, $unsigned(covariance_o));
          check_field("correlation", w.corr, $unsigned(correlation_o));
          check_field("slope", w.slope, $unsigned(slope_o));
          check_field("intercept", w.icpt, $unsigned(intercept_o));
          check_field("deviation", w.dev, deviation_o);
          check_field("degenerate", w.degen, degenerate_o);
        end
      end
      // Only count silence while work is outstanding.
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (sending || pending_fits.size() != 0) begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIM) begin
          $display("watchdog expired with %0d results outstanding", pending_fits.size());
          $display("paired_statistics_linear_fit_tb: FAIL");
          $finish;
        end
      end
    end
  end

  dir_row_t dir_tab[18];

  initial begin
    fit_pts_reset();
    dir_tab[0]  = '{OP_QUERY, 0, -5, 0, 1, '{kind: 1, dev: 5, default: 0}};
    dir_tab[1]  = '{OP_QUERY, POS_MAX, NEG_MIN, 0, 1, '{kind: 1, dev: POS_MAX, default: 0}};
    dir_tab[2]  = '{OP_ADD, 3 * FX_ONE, -2 * FX_ONE, 1, 1,
                    '{count: 1, mean_x: 3 * FX_ONE, mean_y: -2 * FX_ONE, degen: 1, default: 0}};
    dir_tab[3]  = '{OP_QUERY, 9, 7, 0, 1, '{kind: 1, dev: 7, default: 0}};
    dir_tab[4]  = '{OP_ADD, 1 * FX_ONE, 1 * FX_ONE, 0, 0, '{default: 0}};
    dir_tab[5]  = '{OP_ADD, 2 * FX_ONE, 3 * FX_ONE, 0, 0, '{default: 0}};
    dir_tab[6]  = '{OP_ADD, 3 * FX_ONE, 5 * FX_ONE, 1, 0, '{default: 0}};
    dir_tab[7]  = '{OP_QUERY, 10 * FX_ONE, 2 * FX_ONE, 0, 0, '{default: 0}};
    dir_tab[8]  = '{OP_ADD, POS_MAX, 4 * FX_ONE, 0, 0, '{default: 0}};
    dir_tab[9]  = '{OP_ADD, POS_MAX, -4 * FX_ONE, 1, 0, '{default: 0}};
    dir_tab[10] = '{OP_ADD, -7 * FX_ONE, NEG_MIN, 0, 0, '{default: 0}};
    dir_tab[11] = '{OP_ADD, 5 * FX_ONE, NEG_MIN, 1, 0, '{default: 0}};
    dir_tab[12] = '{OP_ADD, NEG_MIN, NEG_MIN, 0, 0, '{default: 0}};
    dir_tab[13] = '{OP_ADD, POS_MAX, POS_MAX, 1, 0, '{default: 0}};
    dir_tab[14] = '{OP_QUERY, NEG_MIN, POS_MAX, 0, 0, '{default: 0}};
    dir_tab[15] = '{OP_ADD, 0, POS_MAX, 0, 0, '{default: 0}};
    dir_tab[16] = '{OP_ADD, POS_MAX, NEG_MIN, 1, 0, '{default: 0}};
    dir_tab[17] = '{OP_QUERY, 3 * FX_ONE, -1, 1, 0, '{default: 0}};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sending = 1'b1;

    foreach (dir_tab[i])
      send_item(dir_tab[i].op, dir_tab[i].x, dir_tab[i].y, dir_tab[i].last,
                dir_tab[i].typed, dir_tab[i].res);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 87; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 87; end
        default: begin send_idle_pct = 25; recv_idle_pct = 25; end
      endcase
      run_random(205);
    end
    in_valid_i <= 1'b0;
    sending = 1'b0;

    while (pending_fits.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);

    $display("covered %0d items, %0d sets finished and %0d results checked", items_sent,
             sets_done, results_seen);
    $display("idle phases: none, sender 87%%, receiver 87%%, both 25%%");
    if (fail_cnt == 0 && pending_fits.size() == 0) begin
      $display("paired_statistics_linear_fit_tb: PASS");
    end else begin
      $display("paired_statistics_linear_fit_tb: FAIL");
    end
    $finish;
  end

endmodule
